// ----- hdl/ifsfpg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsfpg_pkg: shared types and constants for the fern point generator
// Map codes, choice thresholds, register indexes and the control bundle
// that runs between the controller and the datapath.
// ----------------------------------------------------------------------------
package ifsfpg_pkg;

    // Field widths fixed by the interface
    localparam int CHOICE_W   = 10;
    localparam int PIX_W      = 13;
    localparam int SCALE_W    = 8;
    localparam int BASE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Choice thresholds (inclusive upper bounds)
    localparam logic [CHOICE_W-1:0] STEM_MAX = CHOICE_W'(10);
    localparam logic [CHOICE_W-1:0] LEAF_MAX = CHOICE_W'(860);
    localparam logic [CHOICE_W-1:0] LEFT_MAX = CHOICE_W'(930);

    // Pixel saturation limits
    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(60);
    localparam logic [BASE_W-1:0]  CENTER_RST = BASE_W'(690);
    localparam logic [BASE_W-1:0]  HEIGHT_RST = BASE_W'(740);

    // Affine map codes
    typedef enum logic [1:0] {
        MAP_STEM  = 2'd0,
        MAP_LEAF  = 2'd1,
        MAP_LEFT  = 2'd2,
        MAP_RIGHT = 2'd3
    } map_t;

    // Controller to datapath commands
    typedef struct packed {
        logic mul_en;    // capture map, form the four coefficient products
        logic sum_en;    // round, offset, saturate, update the point
        logic scale_en;  // multiply the new point by the scale
        logic out_load;  // round, offset, saturate into the pixel register
    } ctrl_cmd_t;

endpackage

// ----- hdl/ifs_fern_point_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_fern_point_generator_unit: Barnsley fern point generator
// Applies one of four affine maps per choice beat to a fixed-point point
// and emits the screen pixel of the new point.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------
//  in       | input     | in_valid / in_stall | choice_value
//  out      | output    | out_valid/out_stall | pixel_x, pixel_y
//  cfg      | input     | cfg_write_en        | cfg_index, cfg_data
//
//  The coefficient multiply runs at the accept edge; sum and saturate, scale
//  multiply and output load follow in that order, and then the pixel loads.
//  The next beat is accepted only once the sequencer is back in idle after
//  the load; the point feedback keeps beats from overlapping.
//  Reset clears the point to the origin and loads the register defaults.
//  A stalled output holds the pixel; the sequencer waits in its output step.
// ----------------------------------------------------------------------------
module ifs_fern_point_generator_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ifsfpg_pkg::CHOICE_W-1:0]     choice_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ifsfpg_pkg::PIX_W-1:0] pixel_x,
    output logic signed [ifsfpg_pkg::PIX_W-1:0] pixel_y,
    input  logic                                cfg_write_en,
    input  logic [ifsfpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ifsfpg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ifsfpg_pkg::*;

    ctrl_cmd_t cmd;

    ifsfpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    ifsfpg_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .choice_value (choice_value),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y)
    );

endmodule

// ----- hdl/ifsfpg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsfpg_ctrl: sequencer for the fern point generator
// Walks one beat through multiply, sum, scale and output load, and owns
// the input stall and the output valid flag.
// ----------------------------------------------------------------------------
module ifsfpg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ifsfpg_pkg::ctrl_cmd_t  cmd
);
    import ifsfpg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SUM   = 4'b0010,
        ST_SCALE = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_take;
    logic   out_free;

    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.mul_en = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Checks
    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_SUM))
        else $error("accepted beat did not start the sum step");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output valid rose outside the output step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.out_load)
        else $error("pending output beat overwritten");

endmodule

// ----- hdl/ifsfpg_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsfpg_datapath: arithmetic for the fern point generator
// Holds the configuration registers, the point, the coefficient product
// registers, the scale product registers and the pixel output register.
// ----------------------------------------------------------------------------
module ifsfpg_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ifsfpg_pkg::ctrl_cmd_t                  cmd,
    input  logic [ifsfpg_pkg::CHOICE_W-1:0]        choice_value,
    input  logic                                   cfg_write_en,
    input  logic [ifsfpg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ifsfpg_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [ifsfpg_pkg::PIX_W-1:0]    pixel_x,
    output logic signed [ifsfpg_pkg::PIX_W-1:0]    pixel_y
);
    import ifsfpg_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int PW  = 8 + F;            // point width, Q7.F
    localparam int CW  = F + 2;            // signed coefficient width
    localparam int PRW = CW + PW;          // coefficient product width
    localparam int SW  = PRW + 2;          // sum plus offset headroom
    localparam int SPW = PW + SCALE_W + 1; // scale product width

    // Coefficients, round(h/100 * 2^F) half up
    localparam logic signed [CW-1:0] K4   = CW'(((longint'(4)   << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K15  = CW'(((longint'(15)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K16  = CW'(((longint'(16)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K20  = CW'(((longint'(20)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K22  = CW'(((longint'(22)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K23  = CW'(((longint'(23)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K24  = CW'(((longint'(24)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K26  = CW'(((longint'(26)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K28  = CW'(((longint'(28)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K44  = CW'(((longint'(44)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K85  = CW'(((longint'(85)  << F) * 2 + 100) / 200);
    localparam logic signed [CW-1:0] K160 = CW'(((longint'(160) << F) * 2 + 100) / 200);

    localparam logic signed [SW-1:0]  HALF_S  = SW'(longint'(1) << (F - 1));
    localparam logic signed [SPW-1:0] HALF_P  = SPW'(longint'(1) << (F - 1));
    localparam logic signed [SW-1:0]  PT_MAX  = SW'((longint'(1) << (PW - 1)) - 1);
    localparam logic signed [SW-1:0]  PT_MIN  = -PT_MAX - SW'(1);
    localparam logic signed [SPW-1:0] PIX_HI  = SPW'(PIX_MAX);
    localparam logic signed [SPW-1:0] PIX_LO  = SPW'(PIX_MIN);

    // Round a Q.2F sum to Q.F (half away from zero), add offset, saturate
    function automatic logic signed [PW-1:0] make_coord(
        input logic signed [SW-1:0] s,
        input logic signed [SW-1:0] off
    );
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] t;
        r = (s + HALF_S - $signed(SW'(s[SW-1]))) >>> F;
        t = r + off;
        if (t > PT_MAX)
            make_coord = PW'(PT_MAX);
        else if (t < PT_MIN)
            make_coord = PW'(PT_MIN);
        else
            make_coord = PW'(t);
    endfunction

    // Round a scaled coordinate to an integer, half away from zero
    function automatic logic signed [SPW-1:0] round_px(input logic signed [SPW-1:0] p);
        round_px = (p + HALF_P - $signed(SPW'(p[SPW-1]))) >>> F;
    endfunction

    function automatic logic signed [PIX_W-1:0] sat_px(input logic signed [SPW-1:0] v);
        if (v > PIX_HI)
            sat_px = PIX_MAX;
        else if (v < PIX_LO)
            sat_px = PIX_MIN;
        else
            sat_px = PIX_W'(v);
    endfunction

    // Configuration registers
    logic [SCALE_W-1:0] scale_reg;
    logic [BASE_W-1:0]  center_reg;
    logic [BASE_W-1:0]  height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RST;
            center_reg <= CENTER_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_CENTER: center_reg <= cfg_data[BASE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[BASE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Map decode from the choice value
    map_t map_sel;

    always_comb
    begin
        if (choice_value <= STEM_MAX)
            map_sel = MAP_STEM;
        else if (choice_value <= LEAF_MAX)
            map_sel = MAP_LEAF;
        else if (choice_value <= LEFT_MAX)
            map_sel = MAP_LEFT;
        else
            map_sel = MAP_RIGHT;
    end

    // Coefficient selection
    logic signed [CW-1:0] c_xx, c_xy, c_yx, c_yy, c_off;

    always_comb
    begin
        unique case (map_sel)
            MAP_STEM:
            begin
                c_xx = '0;    c_xy = '0;    c_yx = '0;   c_yy = K16; c_off = '0;
            end
            MAP_LEAF:
            begin
                c_xx = K85;   c_xy = K4;    c_yx = -K4;  c_yy = K85; c_off = K160;
            end
            MAP_LEFT:
            begin
                c_xx = K20;   c_xy = -K26;  c_yx = K23;  c_yy = K22; c_off = K160;
            end
            MAP_RIGHT:
            begin
                c_xx = -K15;  c_xy = K28;   c_yx = K26;  c_yy = K24; c_off = K44;
            end
            default:
            begin
                c_xx = '0;    c_xy = '0;    c_yx = '0;   c_yy = '0;  c_off = '0;
            end
        endcase
    end

    // Point state
    logic signed [PW-1:0] point_x_reg, point_y_reg;

    // Coefficient products, one multiplier each
    logic signed [PRW-1:0] p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg;
    logic signed [CW-1:0]  off_y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            p_xx_reg  <= c_xx * point_x_reg;
            p_xy_reg  <= c_xy * point_y_reg;
            p_yx_reg  <= c_yx * point_x_reg;
            p_yy_reg  <= c_yy * point_y_reg;
            off_y_reg <= c_off;
        end
    end

    // New point from the product sums
    logic signed [SW-1:0] sum_x, sum_y;

    assign sum_x = SW'(p_xx_reg) + SW'(p_xy_reg);
    assign sum_y = SW'(p_yx_reg) + SW'(p_yy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg <= '0;
            point_y_reg <= '0;
        end
        else if (cmd.sum_en)
        begin
            point_x_reg <= make_coord(sum_x, '0);
            point_y_reg <= make_coord(sum_y, SW'(off_y_reg));
        end
    end

    // Scale products
    logic signed [SPW-1:0] sp_x_reg, sp_y_reg;
    logic signed [SCALE_W:0] scale_s;

    assign scale_s = $signed({1'b0, scale_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.scale_en)
        begin
            sp_x_reg <= point_x_reg * scale_s;
            sp_y_reg <= point_y_reg * scale_s;
        end
    end

    // Pixel output register
    logic signed [SPW-1:0] pix_x_full, pix_y_full;
    logic signed [PIX_W-1:0] pixel_x_reg, pixel_y_reg;

    assign pix_x_full = $signed(SPW'(center_reg)) + round_px(sp_x_reg);
    assign pix_y_full = $signed(SPW'(height_reg)) - round_px(sp_y_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_x_reg <= sat_px(pix_x_full);
            pixel_y_reg <= sat_px(pix_y_full);
        end
    end

    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;

endmodule

// ----- bench/ifs_fern_point_generator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_fern_point_generator_unit_tb: self-checking bench for the fern generator
// Feeds choice beats under random sender and receiver idling, predicts the
// fixed-point point and pixel of every accepted beat, and compares each pixel
// beat with the oldest prediction. Registers change only while the block is
// idle: reset values first, then extreme settings, then random ones.
// ----------------------------------------------------------------------------
module ifs_fern_point_generator_unit_tb;
    import ifsfpg_pkg::*;

    localparam int FRAC     = 16;
    localparam int PT_W     = 8 + FRAC;
    localparam int SEGMENTS = 9;
    localparam int SEG_BEATS = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index

    typedef struct {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
    } pixel_t;

    // ------------------------------------------------------------------------
    // Fern point predictor and pixel scoreboard
    // ------------------------------------------------------------------------
    class fern_scoreboard;
        logic signed [PT_W-1:0] pt_x;
        logic signed [PT_W-1:0] pt_y;
        logic [SCALE_W-1:0]     scale;
        logic [BASE_W-1:0]      center;
        logic [BASE_W-1:0]      height;
        pixel_t                 pixel_q[$];
        int                     mismatch_cnt;
        int                     beats_checked;
        int                     map_hits[4];

        function new();
            pt_x   = '0;
            pt_y   = '0;
            scale  = SCALE_RST;
            center = CENTER_RST;
            height = HEIGHT_RST;
            mismatch_cnt  = 0;
            beats_checked = 0;
            foreach (map_hits[i]) map_hits[i] = 0;
        endfunction

        // Coefficient in hundredths to Q1.FRAC, rounded half up
        function longint coef(int h);
            return ((longint'(h) << FRAC) * 2 + 100) / 200;
        endfunction

        // Divide by 2^s, half away from zero
        function longint rnd_shift(longint v, int s);
            longint mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (longint'(1) << (s - 1))) >>> s;
            return (v < 0) ? -mag : mag;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint coord(longint prod_sum, longint offset);
            longint lim;
            lim = longint'(1) << (7 + FRAC);
            return clip(rnd_shift(prod_sum, FRAC) + offset, -lim, lim - 1);
        endfunction

        function logic signed [PIX_W-1:0] to_pix(longint v);
            return PIX_W'(clip(v, longint'(PIX_MIN), longint'(PIX_MAX)));
        endfunction

        function map_t pick_map(logic [CHOICE_W-1:0] c);
            if (c <= STEM_MAX) return MAP_STEM;
            if (c <= LEAF_MAX) return MAP_LEAF;
            if (c <= LEFT_MAX) return MAP_LEFT;
            return MAP_RIGHT;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_SCALE:  scale  = d[SCALE_W-1:0];
                CFG_CENTER: center = d[BASE_W-1:0];
                CFG_HEIGHT: height = d[BASE_W-1:0];
                default:    ;
            endcase
        endfunction

        // Accepted choice beat: advance the point and queue its pixel
        function void note_choice(logic [CHOICE_W-1:0] c);
            longint x;
            longint y;
            longint nx;
            longint ny;
            longint sx;
            longint sy;
            map_t   m;
            pixel_t p;
            x = longint'(pt_x);
            y = longint'(pt_y);
            m = pick_map(c);
            map_hits[m]++;
            case (m)
                MAP_STEM:
                begin
                    nx = 0;
                    ny = coord(coef(16) * y, 0);
                end
                MAP_LEAF:
                begin
                    nx = coord(coef(85) * x + coef(4) * y, 0);
                    ny = coord(-coef(4) * x + coef(85) * y, coef(160));
                end
                MAP_LEFT:
                begin
                    nx = coord(coef(20) * x - coef(26) * y, 0);
                    ny = coord(coef(23) * x + coef(22) * y, coef(160));
                end
                default:
                begin
                    nx = coord(-coef(15) * x + coef(28) * y, 0);
                    ny = coord(coef(26) * x + coef(24) * y, coef(44));
                end
            endcase
            pt_x = PT_W'(nx);
            pt_y = PT_W'(ny);
            sx = rnd_shift(nx * longint'(scale), FRAC);
            sy = rnd_shift(ny * longint'(scale), FRAC);
            p.px = to_pix(longint'(center) + sx);
            p.py = to_pix(longint'(height) - sy);
            pixel_q.push_back(p);
        endfunction

        task report_mismatch(string msg);
            mismatch_cnt++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_pixel(logic signed [PIX_W-1:0] px, logic signed [PIX_W-1:0] py);
            pixel_t e;
            if (pixel_q.size() == 0)
            begin
                report_mismatch($sformatf("pixel (%0d,%0d) with no point pending", px, py));
                return;
            end
            e = pixel_q.pop_front();
            beats_checked++;
            if (px !== e.px)
                report_mismatch($sformatf("beat %0d pixel_x %0d, want %0d",
                                          beats_checked, px, e.px));
            if (py !== e.py)
                report_mismatch($sformatf("beat %0d pixel_y %0d, want %0d",
                                          beats_checked, py, e.py));
        endtask

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CHOICE_W-1:0]     choice_value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    int send_idle_pct = 19;
    int recv_idle_pct = 48;
    int settings_used = 1;

    fern_scoreboard sb = new();

    ifs_fern_point_generator_unit #(
        .FRAC_BITS    (FRAC)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .choice_value (choice_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: check the beat taken at this edge, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel(pixel_x, pixel_y);
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Overall limit
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d pixels outstanding", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task send_choice(logic [CHOICE_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        choice_value <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_choice(c);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= d;
        @(posedge clk);
        sb.set_reg(idx, d);
    endtask

    // Write all registers back to back, plus the unmapped index
    task apply_setting(logic [CFG_DATA_W-1:0] s, logic [BASE_W-1:0] c,
                       logic [BASE_W-1:0] h);
        write_reg(CFG_SCALE, s);
        write_reg(CFG_CENTER, c);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(2047)));
        write_reg(CFG_HEIGHT, h);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Let every pending pixel drain, then wait for the block to settle
    task wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function logic [CHOICE_W-1:0] rand_choice();
        int r;
        r = $urandom_range(99);
        if (r < 70) return CHOICE_W'($urandom_range(999));
        if (r < 80) return CHOICE_W'($urandom_range(10));
        if (r < 90) return CHOICE_W'($urandom_range(1023, 1000));
        return CHOICE_W'($urandom_range(1023));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CHOICE_W-1:0] directed[$];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at reset register values: map boundaries, out-of-range
        // choices, all-zero and all-one codes
        directed = '{10'd0, 10'd500, 10'd10, 10'd11, 10'd860, 10'd861, 10'd930,
                     10'd931, 10'd999, 10'd1000, 10'd1023, 10'd5, 10'd700,
                     10'd900, 10'd920, 10'd950, 10'd1, 10'd341, 10'd682,
                     10'd100};
        foreach (directed[i])
            send_choice(directed[i]);

        // Segments: extreme settings first (including scale of zero), then random
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            case (seg)
                0:       apply_setting(11'd0, 11'd0, 11'd0);
                1:       apply_setting(11'd255, 11'd2047, 11'd2047);
                2:       apply_setting(11'd1, 11'd2047, 11'd0);
                3:       apply_setting(11'd255, 11'd0, 11'd2047);
                default: apply_setting({3'($urandom_range(7)), 8'($urandom_range(255, 1))},
                                       BASE_W'($urandom_range(2047)),
                                       BASE_W'($urandom_range(2047)));
            endcase
            if (seg < 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 48;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (SEG_BEATS)
                send_choice(rand_choice());
        end

        wait_idle();
        $display("Checked %0d pixel beats over %0d register settings", sb.beats_checked,
                 settings_used);
        $display("Map use stem/leaf/left/right: %0d/%0d/%0d/%0d", sb.map_hits[MAP_STEM],
                 sb.map_hits[MAP_LEAF], sb.map_hits[MAP_LEFT], sb.map_hits[MAP_RIGHT]);
        if (sb.mismatch_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ifsfpg_pkg.sv
hdl/ifsfpg_ctrl.sv
hdl/ifsfpg_datapath.sv
hdl/ifs_fern_point_generator_unit.sv
bench/ifs_fern_point_generator_unit_tb.sv
